/* design/umx_pkg.sv */
package umx_pkg;

    // Data path widths.
    localparam int WORD_W    = 32;
    localparam int REG_AW    = 3;
    localparam int REG_COUNT = 8;
    localparam int CHAR_W    = 9;
    localparam int ACT_W     = 4;
    localparam int IMM_W     = 25;
    localparam int DIV_CNT_W = 5;

    // Instruction field positions.
    localparam int OPC_LSB = 28;
    localparam int IMM_A_LSB = 25;
    localparam int FIELD_A_LSB = 6;
    localparam int FIELD_B_LSB = 3;
    localparam int FIELD_C_LSB = 0;

    // Last step of the bit-serial divider.
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WORD_W - 1);

    // Opcodes.
    localparam logic [3:0] OP_CMOV    = 4'd0;
    localparam logic [3:0] OP_LOAD    = 4'd1;
    localparam logic [3:0] OP_STORE   = 4'd2;
    localparam logic [3:0] OP_ADD     = 4'd3;
    localparam logic [3:0] OP_MUL     = 4'd4;
    localparam logic [3:0] OP_DIV     = 4'd5;
    localparam logic [3:0] OP_NAND    = 4'd6;
    localparam logic [3:0] OP_HALT    = 4'd7;
    localparam logic [3:0] OP_MAP     = 4'd8;
    localparam logic [3:0] OP_UNMAP   = 4'd9;
    localparam logic [3:0] OP_OUTPUT  = 4'd10;
    localparam logic [3:0] OP_INPUT   = 4'd11;
    localparam logic [3:0] OP_LOADPRG = 4'd12;
    localparam logic [3:0] OP_LOADIMM = 4'd13;

    // Input item kinds.
    localparam logic OPER_EXEC = 1'b0;
    localparam logic OPER_RESP = 1'b1;

    // Result actions.
    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 4'd0,
        ACT_READ     = 4'd1,
        ACT_WRITE    = 4'd2,
        ACT_MAP      = 4'd3,
        ACT_UNMAP    = 4'd4,
        ACT_OUTPUT   = 4'd5,
        ACT_LOADPROG = 4'd6,
        ACT_JUMP     = 4'd7,
        ACT_HALT     = 4'd8,
        ACT_DIVZERO  = 4'd9,
        ACT_ILLEGAL  = 4'd10
    } umx_action_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_EXEC,
        S_DIV,
        S_DONE
    } umx_state_t;

endpackage

/* design/universal_machine_execute_core.sv */
// Execute core of a 32-bit, 14-opcode segmented-memory machine. Each transfer on the input
// channel is either an instruction word fetched at next_pc or a memory response that fills the
// register left pending by a load or map; each produces exactly one result that carries a
// request (read, write, map, unmap, output, load program), a jump, a halt, a fault or
// nothing, plus the next program counter. The eight registers live in a small synchronous
// memory with two read ports and one write port. One item is worked on at a time: a response
// goes from accept straight to write back, most instructions pass through accept, register
// read, execute and write back, and divide runs a one-bit-per-cycle restoring divider between
// execute and write back. A result not yet taken delays only the next item's write-back step.
module universal_machine_execute_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        operation,
    input  logic [31:0] instr_word,
    input  logic [8:0]  in_char,
    input  logic [31:0] mem_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  action,
    output logic [31:0] segment_id,
    output logic [31:0] word_offset,
    output logic [31:0] data_value,
    output logic [31:0] next_pc
);

    localparam int W  = umx_pkg::WORD_W;
    localparam int AW = umx_pkg::REG_AW;

    // Sequencer and architectural state.
    umx_pkg::umx_state_t state_reg, state_next;
    logic [W-1:0]  pc_reg;
    logic [AW-1:0] pend_reg;
    logic          pend_valid_reg;
    logic [umx_pkg::REG_COUNT-1:0] rfv_reg;

    // Latched input item.
    logic [W-1:0] word_reg, word_next;
    logic [umx_pkg::CHAR_W-1:0] char_reg, char_next;

    // Operands.
    logic [W-1:0] vb_reg, vb_next;
    logic [W-1:0] vc_reg, vc_next;

    // Divider.
    logic [W-1:0] rem_reg, rem_next;
    logic [W-1:0] quo_reg, quo_next;
    logic [umx_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [W:0]   div_trial;

    // Pending result of the item at work.
    umx_pkg::umx_action_t res_act_reg, res_act_next;
    logic [W-1:0]  res_seg_reg, res_seg_next;
    logic [W-1:0]  res_off_reg, res_off_next;
    logic [W-1:0]  res_dat_reg, res_dat_next;
    logic [W-1:0]  res_pc_reg, res_pc_next;
    logic          res_we_reg, res_we_next;
    logic [AW-1:0] res_wa_reg, res_wa_next;
    logic [W-1:0]  res_wd_reg, res_wd_next;
    logic [AW-1:0] res_pend_reg, res_pend_next;
    logic          res_pend_valid_reg, res_pend_valid_next;

    // Output register.
    logic          out_valid_reg;
    umx_pkg::umx_action_t out_act_reg;
    logic [W-1:0]  out_seg_reg, out_off_reg, out_dat_reg, out_pc_reg;

    // Register file memory.
    logic [W-1:0]  rf_mem [umx_pkg::REG_COUNT];
    logic [AW-1:0] rd_addr0, rd_addr1;
    logic [W-1:0]  rd0_reg, rd1_reg;
    logic          rd0_ok_reg, rd1_ok_reg;
    logic [W-1:0]  rd0_val, rd1_val;

    logic          accept;
    logic          finish;
    logic          mem_we;

    // Decoded fields of the latched word.
    logic [3:0]    opc;
    logic [AW-1:0] fa, fb, fc, fimm_a;
    logic [W-1:0]  pc_adv;

    assign in_ready = (state_reg == umx_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign finish   = (state_reg == umx_pkg::S_DONE) && (!out_valid_reg || out_ready);
    assign mem_we   = finish && res_we_reg;

    assign opc    = word_reg[umx_pkg::OPC_LSB +: 4];
    assign fa     = word_reg[umx_pkg::FIELD_A_LSB +: AW];
    assign fb     = word_reg[umx_pkg::FIELD_B_LSB +: AW];
    assign fc     = word_reg[umx_pkg::FIELD_C_LSB +: AW];
    assign fimm_a = word_reg[umx_pkg::IMM_A_LSB +: AW];
    assign pc_adv = pc_reg + W'(1);

    // Port 0 reads B on accept and A in the register-read state; port 1 reads C.
    assign rd_addr0 = (state_reg == umx_pkg::S_IDLE) ? instr_word[umx_pkg::FIELD_B_LSB +: AW] : fa;
    assign rd_addr1 = instr_word[umx_pkg::FIELD_C_LSB +: AW];

    // A register never written since reset reads as zero.
    assign rd0_val = rd0_ok_reg ? rd0_reg : '0;
    assign rd1_val = rd1_ok_reg ? rd1_reg : '0;

    // Register file storage with registered reads.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rf_mem[res_wa_reg] <= res_wd_reg;
        end
        rd0_reg <= rf_mem[rd_addr0];
        rd1_reg <= rf_mem[rd_addr1];
    end

    // One restoring divide step.
    assign div_trial = {rem_reg, quo_reg[W-1]} - {1'b0, vc_reg};

    // Next state, execution and result selection.
    always_comb
    begin
        state_next          = state_reg;
        word_next           = word_reg;
        char_next           = char_reg;
        vb_next             = vb_reg;
        vc_next             = vc_reg;
        rem_next            = rem_reg;
        quo_next            = quo_reg;
        cnt_next            = cnt_reg;
        res_act_next        = res_act_reg;
        res_seg_next        = res_seg_reg;
        res_off_next        = res_off_reg;
        res_dat_next        = res_dat_reg;
        res_pc_next         = res_pc_reg;
        res_we_next         = res_we_reg;
        res_wa_next         = res_wa_reg;
        res_wd_next         = res_wd_reg;
        res_pend_next       = res_pend_reg;
        res_pend_valid_next = res_pend_valid_reg;

        unique case (state_reg)
            umx_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    word_next           = instr_word;
                    char_next           = in_char;
                    res_act_next        = umx_pkg::ACT_NONE;
                    res_seg_next        = '0;
                    res_off_next        = '0;
                    res_dat_next        = '0;
                    res_pc_next         = pc_reg;
                    res_we_next         = 1'b0;
                    res_wa_next         = pend_reg;
                    res_wd_next         = mem_data;
                    res_pend_next       = pend_reg;
                    res_pend_valid_next = pend_valid_reg;
                    priority if (operation == umx_pkg::OPER_RESP)
                    begin
                        // A response fills the pending register, if any.
                        res_we_next         = pend_valid_reg;
                        res_pend_valid_next = 1'b0;
                        state_next          = umx_pkg::S_DONE;
                    end
                    else if (pend_valid_reg)
                    begin
                        // Instructions are ignored while a response is owed.
                        state_next = umx_pkg::S_DONE;
                    end
                    else
                    begin
                        state_next = umx_pkg::S_READ;
                    end
                end
            end

            umx_pkg::S_READ:
            begin
                vb_next    = rd0_val;
                vc_next    = rd1_val;
                state_next = umx_pkg::S_EXEC;
            end

            umx_pkg::S_EXEC:
            begin
                state_next  = umx_pkg::S_DONE;
                res_pc_next = pc_adv;
                res_wa_next = fa;
                unique case (opc)
                    umx_pkg::OP_CMOV:
                    begin
                        res_we_next = (vc_reg != '0);
                        res_wd_next = vb_reg;
                    end
                    umx_pkg::OP_LOAD:
                    begin
                        res_act_next        = umx_pkg::ACT_READ;
                        res_seg_next        = vb_reg;
                        res_off_next        = vc_reg;
                        res_pend_next       = fa;
                        res_pend_valid_next = 1'b1;
                    end
                    umx_pkg::OP_STORE:
                    begin
                        res_act_next = umx_pkg::ACT_WRITE;
                        res_seg_next = rd0_val;
                        res_off_next = vb_reg;
                        res_dat_next = vc_reg;
                    end
                    umx_pkg::OP_ADD:
                    begin
                        res_we_next = 1'b1;
                        res_wd_next = vb_reg + vc_reg;
                    end
                    umx_pkg::OP_MUL:
                    begin
                        res_we_next = 1'b1;
                        res_wd_next = W'(vb_reg * vc_reg);
                    end
                    umx_pkg::OP_DIV:
                    begin
                        if (vc_reg == '0)
                        begin
                            res_act_next = umx_pkg::ACT_DIVZERO;
                            res_pc_next  = pc_reg;
                        end
                        else
                        begin
                            res_we_next = 1'b1;
                            rem_next    = '0;
                            quo_next    = vb_reg;
                            cnt_next    = '0;
                            state_next  = umx_pkg::S_DIV;
                        end
                    end
                    umx_pkg::OP_NAND:
                    begin
                        res_we_next = 1'b1;
                        res_wd_next = ~(vb_reg & vc_reg);
                    end
                    umx_pkg::OP_HALT:
                    begin
                        res_act_next = umx_pkg::ACT_HALT;
                        res_pc_next  = pc_reg;
                    end
                    umx_pkg::OP_MAP:
                    begin
                        res_act_next        = umx_pkg::ACT_MAP;
                        res_off_next        = vc_reg;
                        res_pend_next       = fb;
                        res_pend_valid_next = 1'b1;
                    end
                    umx_pkg::OP_UNMAP:
                    begin
                        res_act_next = umx_pkg::ACT_UNMAP;
                        res_seg_next = vc_reg;
                    end
                    umx_pkg::OP_OUTPUT:
                    begin
                        res_act_next = umx_pkg::ACT_OUTPUT;
                        res_dat_next = {{(W-8){1'b0}}, vc_reg[7:0]};
                    end
                    umx_pkg::OP_INPUT:
                    begin
                        // End of input loads all ones.
                        res_we_next = 1'b1;
                        res_wa_next = fc;
                        res_wd_next = char_reg[8] ? '1 : {{(W-8){1'b0}}, char_reg[7:0]};
                    end
                    umx_pkg::OP_LOADPRG:
                    begin
                        res_act_next = (vb_reg != '0) ? umx_pkg::ACT_LOADPROG
                                                      : umx_pkg::ACT_JUMP;
                        res_seg_next = vb_reg;
                        res_pc_next  = vc_reg;
                    end
                    umx_pkg::OP_LOADIMM:
                    begin
                        res_we_next = 1'b1;
                        res_wa_next = fimm_a;
                        res_wd_next = {{(W-umx_pkg::IMM_W){1'b0}}, word_reg[umx_pkg::IMM_W-1:0]};
                    end
                    default:
                    begin
                        res_act_next = umx_pkg::ACT_ILLEGAL;
                        res_pc_next  = pc_reg;
                    end
                endcase
            end

            umx_pkg::S_DIV:
            begin
                if (!div_trial[W])
                begin
                    rem_next = div_trial[W-1:0];
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = {rem_reg[W-2:0], quo_reg[W-1]};
                    quo_next = {quo_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == umx_pkg::DIV_LAST)
                begin
                    res_wd_next = quo_next;
                    state_next  = umx_pkg::S_DONE;
                end
            end

            umx_pkg::S_DONE:
            begin
                if (finish)
                begin
                    state_next = umx_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = umx_pkg::S_IDLE;
            end
        endcase
    end

    // Control state, valid bits and output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= umx_pkg::S_IDLE;
            pc_reg         <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            rfv_reg        <= '0;
            rd0_ok_reg     <= 1'b0;
            rd1_ok_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd0_ok_reg <= rfv_reg[rd_addr0];
            rd1_ok_reg <= rfv_reg[rd_addr1];
            if (mem_we)
            begin
                rfv_reg[res_wa_reg] <= 1'b1;
            end
            if (finish)
            begin
                pc_reg         <= res_pc_reg;
                pend_reg       <= res_pend_reg;
                pend_valid_reg <= res_pend_valid_reg;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg           <= word_next;
        char_reg           <= char_next;
        vb_reg             <= vb_next;
        vc_reg             <= vc_next;
        rem_reg            <= rem_next;
        quo_reg            <= quo_next;
        cnt_reg            <= cnt_next;
        res_act_reg        <= res_act_next;
        res_seg_reg        <= res_seg_next;
        res_off_reg        <= res_off_next;
        res_dat_reg        <= res_dat_next;
        res_pc_reg         <= res_pc_next;
        res_we_reg         <= res_we_next;
        res_wa_reg         <= res_wa_next;
        res_wd_reg         <= res_wd_next;
        res_pend_reg       <= res_pend_next;
        res_pend_valid_reg <= res_pend_valid_next;
        if (finish)
        begin
            out_act_reg <= res_act_reg;
            out_seg_reg <= res_seg_reg;
            out_off_reg <= res_off_reg;
            out_dat_reg <= res_dat_reg;
            out_pc_reg  <= res_pc_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = out_act_reg;
    assign segment_id  = out_seg_reg;
    assign word_offset = out_off_reg;
    assign data_value  = out_dat_reg;
    assign next_pc     = out_pc_reg;

    // A shown result always carries the counter the core now holds.
    a_out_pc_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pc_reg == pc_reg))
        else $error("shown next_pc differs from the program counter");

    // The register file is written only at write-back.
    a_we_in_done: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == umx_pkg::S_DONE))
        else $error("register write outside write-back");

    // The divider never runs with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == umx_pkg::S_DIV) |-> (vc_reg != '0))
        else $error("divider running with zero divisor");

    // An accepted item always leaves the idle state.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != umx_pkg::S_IDLE))
        else $error("core stayed idle after an input transfer");

endmodule
